// File: rtl/i2cms_pkg.sv
// Package: types, codes and constants of the I2C master transfer sequencer.
package i2cms_pkg;

	localparam logic [7:0] MAX_TRANSFER = 8'd255;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_EVENT = 2'd2;

	localparam logic [7:0] ST_START_SENT = 8'h08;
	localparam logic [7:0] ST_SLA_W_ACK  = 8'h18;
	localparam logic [7:0] ST_DATA_W_ACK = 8'h28;
	localparam logic [7:0] ST_SLA_R_ACK  = 8'h40;
	localparam logic [7:0] ST_DATA_R_ACK = 8'h50;
	localparam logic [7:0] ST_CLASS_MASK = 8'hf0;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_START = 3'd1,
		PH_ADDR  = 3'd2,
		PH_DATA  = 3'd3
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic       is_read;
		logic [7:0] bytes_left;
		logic [6:0] target_address;
	} seq_state_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [6:0] dev_address;
		logic [7:0] transfer_count;
		logic [7:0] bus_status;
		logic [7:0] rx_byte;
		logic [7:0] tx_byte;
	} req_beat_t;

	typedef struct packed {
		logic       set_start;
		logic       set_stop;
		logic       clear_start;
		logic       clear_irq;
		logic       ack_on;
		logic       ack_off;
		logic       load_tx;
		logic [7:0] tx_data;
		logic       rx_valid;
		logic [7:0] rx_data;
		logic       done_res;
		logic       success;
	} rsp_beat_t;

endpackage

// File: rtl/i2cms_step.sv
// Next-state and result logic for one request beat.
module i2cms_step (
	input  i2cms_pkg::seq_state_t state,
	input  i2cms_pkg::req_beat_t  req,
	output i2cms_pkg::seq_state_t state_nxt,
	output i2cms_pkg::rsp_beat_t  rsp
);

	logic [7:0] dec_left;
	logic       fin;
	logic       fin_ok;

	assign dec_left = state.bytes_left - 8'd1;

	always_comb begin
		state_nxt = state;
		rsp       = '0;
		fin       = 1'b0;
		fin_ok    = 1'b0;
		if (req.mode == i2cms_pkg::MODE_WRITE || req.mode == i2cms_pkg::MODE_READ) begin
			if (state.phase == i2cms_pkg::PH_IDLE) begin
				state_nxt.is_read        = req.mode[0];
				state_nxt.target_address = req.dev_address;
				state_nxt.bytes_left     = (req.transfer_count > i2cms_pkg::MAX_TRANSFER) ?
					i2cms_pkg::MAX_TRANSFER : req.transfer_count;
				state_nxt.phase          = i2cms_pkg::PH_START;
				rsp.set_start            = 1'b1;
			end
		end else if (req.mode == i2cms_pkg::MODE_EVENT) begin
			unique case (state.phase)
				i2cms_pkg::PH_START: begin
					if (req.bus_status == i2cms_pkg::ST_START_SENT) begin
						rsp.load_tx     = 1'b1;
						rsp.tx_data     = {state.target_address, state.is_read};
						rsp.clear_irq   = 1'b1;
						rsp.clear_start = 1'b1;
						state_nxt.phase = i2cms_pkg::PH_ADDR;
					end else begin
						fin    = 1'b1;
						fin_ok = state.is_read && (state.bytes_left == 8'd0);
					end
				end
				i2cms_pkg::PH_ADDR, i2cms_pkg::PH_DATA: begin
					if (!state.is_read) begin
						if ((state.phase == i2cms_pkg::PH_ADDR &&
						     req.bus_status == i2cms_pkg::ST_SLA_W_ACK) ||
						    (state.phase == i2cms_pkg::PH_DATA &&
						     req.bus_status == i2cms_pkg::ST_DATA_W_ACK)) begin
							if (state.bytes_left != 8'd0) begin
								rsp.load_tx          = 1'b1;
								rsp.tx_data          = req.tx_byte;
								rsp.clear_irq        = 1'b1;
								state_nxt.bytes_left = dec_left;
								state_nxt.phase      = i2cms_pkg::PH_DATA;
							end else begin
								fin    = 1'b1;
								fin_ok = 1'b1;
							end
						end else begin
							fin = 1'b1;
						end
					end else if (state.phase == i2cms_pkg::PH_ADDR) begin
						if (req.bus_status == i2cms_pkg::ST_SLA_R_ACK) begin
							rsp.ack_on = 1'b1;
							if (state.bytes_left == 8'd0) begin
								fin    = 1'b1;
								fin_ok = 1'b1;
							end else begin
								rsp.ack_off     = (state.bytes_left == 8'd1);
								rsp.clear_irq   = 1'b1;
								state_nxt.phase = i2cms_pkg::PH_DATA;
							end
						end else begin
							fin    = 1'b1;
							fin_ok = (state.bytes_left == 8'd0);
						end
					end else if ((req.bus_status & i2cms_pkg::ST_CLASS_MASK) !=
					             i2cms_pkg::ST_DATA_R_ACK) begin
						fin    = 1'b1;
						fin_ok = (state.bytes_left == 8'd0);
					end else begin
						state_nxt.bytes_left = dec_left;
						rsp.rx_valid         = 1'b1;
						rsp.rx_data          = req.rx_byte;
						if (req.bus_status != i2cms_pkg::ST_DATA_R_ACK || dec_left == 8'd0) begin
							fin    = 1'b1;
							fin_ok = (dec_left == 8'd0);
						end else begin
							rsp.ack_off   = (dec_left == 8'd1);
							rsp.clear_irq = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
		if (fin) begin
			rsp.set_stop    = 1'b1;
			rsp.clear_irq   = 1'b1;
			rsp.ack_off     = rsp.ack_off | state.is_read;
			rsp.done_res    = 1'b1;
			rsp.success     = fin_ok;
			state_nxt.phase = i2cms_pkg::PH_IDLE;
		end
	end

endmodule

// File: rtl/i2cms_out_reg.sv
// Result register with valid/stall handshake toward the receiver.
module i2cms_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  i2cms_pkg::rsp_beat_t rsp_nxt,
	output logic                 busy,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output i2cms_pkg::rsp_beat_t rsp
);

	logic                 valid_q;
	i2cms_pkg::rsp_beat_t rsp_q;

	assign busy      = valid_q && rsp_stall;
	assign rsp_valid = valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= rsp_nxt;
		end
	end

endmodule

// File: rtl/i2c_master_transfer_sequencer.sv
// Top level of the I2C master transfer sequencer.
// Request channel (req_valid, req_stall, req): one beat is a start request
// (mode write or read, with address and byte count) or a status event from
// the byte engine (status code, received byte, next byte to send).
// Response channel (rsp_valid, rsp_stall, rsp): exactly one beat per request
// beat, carrying the engine controls, received data, done and success.
// A request accepted at one edge shows its registered response in the next
// cycle. Throughput: one beat per cycle while rsp_stall is low, set by the
// single state update between the state registers and the result register.
// Reset clears the phase to idle, the saved transfer state and the
// response valid; no response is pending after reset.
// When the receiver stalls a pending response, req_stall rises in the same
// cycle and holds requests off until the response is taken; the response
// beat holds still meanwhile.
module i2c_master_transfer_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  i2cms_pkg::req_beat_t req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output i2cms_pkg::rsp_beat_t rsp
);

	i2cms_pkg::seq_state_t state_q;
	i2cms_pkg::seq_state_t state_nxt;
	i2cms_pkg::rsp_beat_t  rsp_nxt;
	logic                  accept;

	assign accept = req_valid && !req_stall;

	i2cms_step u_step (
		.state     (state_q),
		.req       (req),
		.state_nxt (state_nxt),
		.rsp       (rsp_nxt)
	);

	i2cms_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.rsp_nxt   (rsp_nxt),
		.busy      (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: i2cms_pkg::PH_IDLE, is_read: 1'b0,
			             bytes_left: 8'd0, target_address: 7'd0};
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

endmodule

// File: rtl/i2cms_checker.sv
// Port checker for the I2C master transfer sequencer, bound to the top level.
module i2cms_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_stall,
	input i2cms_pkg::req_beat_t req,
	input logic                 rsp_valid,
	input logic                 rsp_stall,
	input i2cms_pkg::rsp_beat_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response beat changed");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |-> req_stall)
		else $error("request taken while response stalled");

	a_success_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.done_res |-> !rsp.success)
		else $error("success without done");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.load_tx || rsp.tx_data == 8'd0) &&
		              (rsp.rx_valid || rsp.rx_data == 8'd0))
		else $error("data field set without its flag");

	a_one_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> rsp_valid)
		else $error("accepted request gave no response");

endmodule

bind i2c_master_transfer_sequencer i2cms_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// File: bench/i2c_master_transfer_sequencer_test.sv
// Self-checking testbench of the I2C master transfer sequencer: directed table, then random.
module i2c_master_transfer_sequencer_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 500;

	typedef struct {
		i2cms_pkg::req_beat_t beat;
		bit                   typed;
		i2cms_pkg::rsp_beat_t want;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	i2cms_pkg::req_beat_t req = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	i2cms_pkg::rsp_beat_t rsp;

	i2cms_pkg::phase_t seq_phase = i2cms_pkg::PH_IDLE;
	logic              seq_read = 1'b0;
	logic [7:0]        seq_left = '0;
	logic [6:0]        seq_addr = '0;

	i2cms_pkg::rsp_beat_t pending_controls[$];
	stim_row_t            stim_table[$];

	int fails = 0;
	int quiet = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_asked = 0;
	int hold_served = 0;
	int hold_left = 0;

	i2c_master_transfer_sequencer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void close_transfer(inout i2cms_pkg::rsp_beat_t o, input logic ok);
		o.set_stop = 1'b1;
		o.clear_irq = 1'b1;
		if (seq_read) begin
			o.ack_off = 1'b1;
		end
		o.done_res = 1'b1;
		o.success = ok;
		seq_phase = i2cms_pkg::PH_IDLE;
	endfunction

	function automatic void send_next_byte(inout i2cms_pkg::rsp_beat_t o,
		input logic [7:0] data);
		if (seq_left != 8'd0) begin
			o.load_tx = 1'b1;
			o.tx_data = data;
			o.clear_irq = 1'b1;
			seq_left = seq_left - 8'd1;
			seq_phase = i2cms_pkg::PH_DATA;
		end else begin
			close_transfer(o, 1'b1);
		end
	endfunction

	function automatic i2cms_pkg::rsp_beat_t next_controls(input i2cms_pkg::req_beat_t b);
		i2cms_pkg::rsp_beat_t o;
		logic [7:0]           cnt;
		o = '0;
		if (b.mode == i2cms_pkg::MODE_WRITE || b.mode == i2cms_pkg::MODE_READ) begin
			if (seq_phase == i2cms_pkg::PH_IDLE) begin
				cnt = b.transfer_count;
				if (cnt > i2cms_pkg::MAX_TRANSFER) begin
					cnt = i2cms_pkg::MAX_TRANSFER;
				end
				seq_read = (b.mode == i2cms_pkg::MODE_READ);
				seq_addr = b.dev_address;
				seq_left = cnt;
				o.set_start = 1'b1;
				seq_phase = i2cms_pkg::PH_START;
			end
		end else if (b.mode == i2cms_pkg::MODE_EVENT) begin
			case (seq_phase)
				i2cms_pkg::PH_START: begin
					if (b.bus_status == i2cms_pkg::ST_START_SENT) begin
						o.load_tx = 1'b1;
						o.tx_data = {seq_addr, seq_read};
						o.clear_irq = 1'b1;
						o.clear_start = 1'b1;
						seq_phase = i2cms_pkg::PH_ADDR;
					end else begin
						close_transfer(o, seq_read && seq_left == 8'd0);
					end
				end
				i2cms_pkg::PH_ADDR: begin
					if (!seq_read) begin
						if (b.bus_status == i2cms_pkg::ST_SLA_W_ACK) begin
							send_next_byte(o, b.tx_byte);
						end else begin
							close_transfer(o, 1'b0);
						end
					end else if (b.bus_status == i2cms_pkg::ST_SLA_R_ACK) begin
						o.ack_on = 1'b1;
						if (seq_left == 8'd0) begin
							close_transfer(o, 1'b1);
						end else begin
							if (seq_left == 8'd1) begin
								o.ack_off = 1'b1;
							end
							o.clear_irq = 1'b1;
							seq_phase = i2cms_pkg::PH_DATA;
						end
					end else begin
						close_transfer(o, seq_left == 8'd0);
					end
				end
				i2cms_pkg::PH_DATA: begin
					if (!seq_read) begin
						if (b.bus_status == i2cms_pkg::ST_DATA_W_ACK) begin
							send_next_byte(o, b.tx_byte);
						end else begin
							close_transfer(o, 1'b0);
						end
					end else if ((b.bus_status & i2cms_pkg::ST_CLASS_MASK) !=
					             i2cms_pkg::ST_DATA_R_ACK) begin
						close_transfer(o, seq_left == 8'd0);
					end else begin
						seq_left = seq_left - 8'd1;
						o.rx_valid = 1'b1;
						o.rx_data = b.rx_byte;
						if (b.bus_status != i2cms_pkg::ST_DATA_R_ACK || seq_left == 8'd0) begin
							close_transfer(o, seq_left == 8'd0);
						end else begin
							if (seq_left == 8'd1) begin
								o.ack_off = 1'b1;
							end
							o.clear_irq = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
		return o;
	endfunction

	function automatic string show(input i2cms_pkg::rsp_beat_t r);
		return $sformatf({"start=%0b stop=%0b clr_start=%0b clr_irq=%0b ack_on=%0b ack_off=%0b ",
			"load=%0b tx=%02h rx_valid=%0b rx=%02h done=%0b ok=%0b"},
			r.set_start, r.set_stop, r.clear_start, r.clear_irq, r.ack_on, r.ack_off,
			r.load_tx, r.tx_data, r.rx_valid, r.rx_data, r.done_res, r.success);
	endfunction

	function automatic i2cms_pkg::req_beat_t mk_beat(input logic [1:0] mode,
		input logic [6:0] addr, input logic [7:0] cnt, input logic [7:0] st,
		input logic [7:0] rxb, input logic [7:0] txb);
		i2cms_pkg::req_beat_t b;
		b.mode = mode;
		b.dev_address = addr;
		b.transfer_count = cnt;
		b.bus_status = st;
		b.rx_byte = rxb;
		b.tx_byte = txb;
		return b;
	endfunction

	function automatic i2cms_pkg::rsp_beat_t ctl(input int start, stop, clr_start, clr_irq,
		aon, aoff, load, input logic [7:0] txd, input int rxv, input logic [7:0] rxd,
		input int done, ok);
		i2cms_pkg::rsp_beat_t r;
		r.set_start = 1'(start);
		r.set_stop = 1'(stop);
		r.clear_start = 1'(clr_start);
		r.clear_irq = 1'(clr_irq);
		r.ack_on = 1'(aon);
		r.ack_off = 1'(aoff);
		r.load_tx = 1'(load);
		r.tx_data = txd;
		r.rx_valid = 1'(rxv);
		r.rx_data = rxd;
		r.done_res = 1'(done);
		r.success = 1'(ok);
		return r;
	endfunction

	function automatic i2cms_pkg::req_beat_t random_beat();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[$bits(i2cms_pkg::req_beat_t)-1:0];
	endfunction

	task automatic add_row(input i2cms_pkg::req_beat_t b, input bit typed,
		input i2cms_pkg::rsp_beat_t want);
		stim_row_t row;
		row.beat = b;
		row.typed = typed;
		row.want = want;
		stim_table.push_back(row);
	endtask

	task automatic send_beat(input i2cms_pkg::req_beat_t b, input bit typed,
		input i2cms_pkg::rsp_beat_t want);
		i2cms_pkg::rsp_beat_t guess;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= b;
		@(posedge clk);
		while (req_stall !== 1'b0) begin
			@(posedge clk);
		end
		guess = next_controls(b);
		pending_controls.push_back(typed ? want : guess);
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_controls.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic run_transfer(inout int n);
		i2cms_pkg::req_beat_t b;
		b = random_beat();
		b.mode = 2'($urandom_range(0, 1));
		b.transfer_count = ($urandom_range(0, 99) < 3) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 4));
		send_beat(b, 1'b0, '0);
		n++;
		while (seq_phase != i2cms_pkg::PH_IDLE) begin
			b = random_beat();
			if ($urandom_range(0, 99) < 4) begin
				b.mode = $urandom_range(0, 1) ? 2'd3 : 2'($urandom_range(0, 1));
				send_beat(b, 1'b0, '0);
			end else begin
				b.mode = i2cms_pkg::MODE_EVENT;
				case (seq_phase)
					i2cms_pkg::PH_START: b.bus_status = i2cms_pkg::ST_START_SENT;
					i2cms_pkg::PH_ADDR: b.bus_status = seq_read ? i2cms_pkg::ST_SLA_R_ACK
						: i2cms_pkg::ST_SLA_W_ACK;
					default: begin
						if (!seq_read) begin
							b.bus_status = i2cms_pkg::ST_DATA_W_ACK;
						end else if (seq_left == 8'd1 && $urandom_range(0, 1)) begin
							b.bus_status = i2cms_pkg::ST_DATA_R_ACK | 8'h08;
						end else if ($urandom_range(0, 99) < 5) begin
							b.bus_status = i2cms_pkg::ST_DATA_R_ACK | 8'($urandom_range(0, 15));
						end else begin
							b.bus_status = i2cms_pkg::ST_DATA_R_ACK;
						end
					end
				endcase
				if ($urandom_range(0, 99) < 3) begin
					b.bus_status = 8'($urandom);
				end
				send_beat(b, 1'b0, '0);
				n++;
			end
		end
	endtask

	always @(negedge clk) begin
		if (hold_left != 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_asked != hold_served) begin
			hold_served <= hold_asked;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		i2cms_pkg::rsp_beat_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
			if (pending_controls.size() == 0) begin
				fails++;
				if (fails <= 10) begin
					$display("unexpected beat: %s", show(rsp));
				end
			end else begin
				want = pending_controls.pop_front();
				if (rsp !== want) begin
					fails++;
					if (fails <= 10) begin
						$display("mismatch at %0t", $realtime);
						$display("  exp %s", show(want));
						$display("  got %s", show(rsp));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet >= QUIET_LIMIT) begin
			$display("timeout: no beat for %0d cycles", quiet);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int n;
		i2cms_pkg::req_beat_t b;

		add_row(mk_beat(i2cms_pkg::MODE_EVENT, 7'h7f, 8'hff, i2cms_pkg::ST_START_SENT,
			8'hff, 8'hff), 1'b1, '0);
		add_row(mk_beat(2'd3, 7'h7f, 8'hff, 8'hff, 8'hff, 8'hff), 1'b1, '0);
		add_row(mk_beat(i2cms_pkg::MODE_WRITE, 7'h7f, 8'd0, 8'h00, 8'h00, 8'h00), 1'b1,
			ctl(1, 0, 0, 0, 0, 0, 0, 8'h00, 0, 8'h00, 0, 0));
		add_row(mk_beat(i2cms_pkg::MODE_READ, 7'h00, 8'd5, 8'h00, 8'h00, 8'h00), 1'b1, '0);
		add_row(mk_beat(i2cms_pkg::MODE_EVENT, 7'h00, 8'd0, i2cms_pkg::ST_START_SENT,
			8'h00, 8'h00), 1'b1, ctl(0, 0, 1, 1, 0, 0, 1, 8'hfe, 0, 8'h00, 0, 0));
		add_row(mk_beat(i2cms_pkg::MODE_EVENT, 7'h00, 8'd0, i2cms_pkg::ST_SLA_W_ACK,
			8'hff, 8'hff), 1'b1, ctl(0, 1, 0, 1, 0, 0, 0, 8'h00, 0, 8'h00, 1, 1));
		add_row(mk_beat(i2cms_pkg::MODE_READ, 7'h00, 8'd0, 8'h00, 8'h00, 8'h00), 1'b1,
			ctl(1, 0, 0, 0, 0, 0, 0, 8'h00, 0, 8'h00, 0, 0));
		add_row(mk_beat(i2cms_pkg::MODE_EVENT, 7'h7f, 8'd0, i2cms_pkg::ST_START_SENT,
			8'h00, 8'h00), 1'b1, ctl(0, 0, 1, 1, 0, 0, 1, 8'h01, 0, 8'h00, 0, 0));
		add_row(mk_beat(i2cms_pkg::MODE_EVENT, 7'h00, 8'd0, i2cms_pkg::ST_SLA_R_ACK,
			8'hff, 8'h00), 1'b1, ctl(0, 1, 0, 1, 1, 1, 0, 8'h00, 0, 8'h00, 1, 1));
		add_row(mk_beat(i2cms_pkg::MODE_READ, 7'h55, 8'd2, 8'h00, 8'h00, 8'h00), 1'b0, '0);
		add_row(mk_beat(i2cms_pkg::MODE_EVENT, 7'h00, 8'd0, i2cms_pkg::ST_START_SENT,
			8'h00, 8'h00), 1'b0, '0);
		add_row(mk_beat(i2cms_pkg::MODE_EVENT, 7'h00, 8'd0, i2cms_pkg::ST_SLA_R_ACK,
			8'h00, 8'h00), 1'b0, '0);
		add_row(mk_beat(i2cms_pkg::MODE_EVENT, 7'h00, 8'd0, i2cms_pkg::ST_DATA_R_ACK,
			8'hff, 8'h00), 1'b0, '0);
		add_row(mk_beat(i2cms_pkg::MODE_EVENT, 7'h00, 8'd0, i2cms_pkg::ST_DATA_R_ACK | 8'h08,
			8'h00, 8'hff), 1'b0, '0);
		add_row(mk_beat(i2cms_pkg::MODE_WRITE, 7'h2a, 8'd255, 8'h00, 8'h00, 8'h00), 1'b0, '0);
		add_row(mk_beat(i2cms_pkg::MODE_EVENT, 7'h00, 8'd0, i2cms_pkg::ST_START_SENT,
			8'h00, 8'h00), 1'b0, '0);
		add_row(mk_beat(i2cms_pkg::MODE_EVENT, 7'h00, 8'd0, i2cms_pkg::ST_SLA_W_ACK,
			8'h00, 8'hff), 1'b0, '0);
		add_row(mk_beat(i2cms_pkg::MODE_EVENT, 7'h00, 8'd0, i2cms_pkg::ST_DATA_W_ACK,
			8'h00, 8'h00), 1'b0, '0);
		add_row(mk_beat(i2cms_pkg::MODE_EVENT, 7'h00, 8'd0, 8'h30, 8'h00, 8'h00), 1'b1,
			ctl(0, 1, 0, 1, 0, 0, 0, 8'h00, 0, 8'h00, 1, 0));
		add_row(mk_beat(i2cms_pkg::MODE_READ, 7'h7f, 8'd3, 8'h00, 8'h00, 8'h00), 1'b0, '0);
		add_row(mk_beat(i2cms_pkg::MODE_EVENT, 7'h00, 8'd0, i2cms_pkg::ST_START_SENT,
			8'h00, 8'h00), 1'b0, '0);
		add_row(mk_beat(i2cms_pkg::MODE_EVENT, 7'h00, 8'd0, i2cms_pkg::ST_SLA_R_ACK,
			8'h00, 8'h00), 1'b0, '0);
		add_row(mk_beat(i2cms_pkg::MODE_EVENT, 7'h00, 8'd0, i2cms_pkg::ST_DATA_R_ACK | 8'h08,
			8'ha5, 8'h00), 1'b0, '0);
		add_row(mk_beat(i2cms_pkg::MODE_READ, 7'h3c, 8'd0, 8'h00, 8'h00, 8'h00), 1'b0, '0);
		add_row(mk_beat(i2cms_pkg::MODE_EVENT, 7'h00, 8'd0, 8'h00, 8'h00, 8'h00), 1'b1,
			ctl(0, 1, 0, 1, 0, 1, 0, 8'h00, 0, 8'h00, 1, 1));

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		foreach (stim_table[i]) begin
			send_beat(stim_table[i].beat, stim_table[i].typed, stim_table[i].want);
		end
		drain();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
					hold_asked++;
				end
				1: begin
					send_idle_pct = 80;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 80;
				end
				default: begin
					send_idle_pct = 20;
					stall_pct = 20;
				end
			endcase
			n = 0;
			while (n < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 5) begin
					b = random_beat();
					b.mode = $urandom_range(0, 1) ? 2'd3 : i2cms_pkg::MODE_EVENT;
					send_beat(b, 1'b0, '0);
				end else begin
					run_transfer(n);
				end
			end
			drain();
		end

		@(negedge clk);
		req_valid <= 1'b0;
		drain();
		repeat (4) @(posedge clk);
		if (pending_controls.size() != 0) begin
			fails += pending_controls.size();
			$display("%0d expected beats never arrived", pending_controls.size());
		end
		if (fails == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
